// ===== hw/rtl/imd_pkg.sv =====
// Shared types and constants for the stream metadata demultiplexer.
// Used by the front, queue, back and top-level modules; no dependencies.
package imd_pkg;

    // Longest title run and the scan window within one metadata block.
    localparam int TITLE_MAX   = 48;
    localparam int SCAN_LIMIT  = 4096;
    localparam int TITLE_CNT_W = 6;
    localparam int TITLE_IDX_W = $clog2(TITLE_MAX);

    // Command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Match progress codes for the title tag search.
    localparam logic [3:0] PAT_LEN      = 4'd12;
    localparam logic [3:0] STEP_SKIP    = 4'd12;
    localparam logic [3:0] STEP_CAPTURE = 4'd13;
    localparam logic [3:0] STEP_DONE    = 4'd14;
    localparam logic [3:0] STEP_OVER    = 4'd15;

    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_S    = 8'h53;

    // Result kind carried on tuser.
    typedef enum logic [1:0] {
        KIND_AUDIO = 2'd0,
        KIND_LEN   = 2'd1,
        KIND_META  = 2'd2,
        KIND_TITLE = 2'd3
    } t_kind;

    // One classified byte plus the length of the title run it releases.
    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              data;
        logic [TITLE_CNT_W-1:0]  run;
    } t_cmd;

    // Title store write request from the front.
    typedef struct packed {
        logic                    en;
        logic [TITLE_IDX_W-1:0]  addr;
        logic [7:0]              data;
    } t_store_wr;

    // Characters of the tag "StreamTitle=".
    function automatic logic [7:0] tag_char(input logic [3:0] step);
        logic [7:0] c;
        case (step)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h72;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h65;
            4'd11:   c = 8'h3D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/imd_front.sv =====
// Front end: accepts stream bytes, tracks framing, scans for the title tag.
// Depends on imd_pkg; feeds imd_queue and writes the title store in imd_back.
module imd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [19:0]            i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,     // stream_byte
    input  logic                   i_full,
    output logic                   o_push,
    output imd_pkg::t_cmd          o_cmd,
    output imd_pkg::t_store_wr     o_store_wr,
    input  logic                   i_run_done
);
    import imd_pkg::*;

    typedef enum logic [1:0] {
        PH_AUDIO = 2'b01,
        PH_META  = 2'b10
    } t_phase;

    localparam logic [12:0] SCAN_LAST = 13'(SCAN_LIMIT - 1);

    logic [19:0]            r_interval, n_interval;
    logic [19:0]            r_audio_left, n_audio_left;
    t_phase                 r_phase, n_phase;
    logic [11:0]            r_meta_left, n_meta_left;
    logic [11:0]            r_meta_pos, n_meta_pos;
    logic [3:0]             r_step, n_step;
    logic [TITLE_CNT_W-1:0] r_count, n_count;
    logic                   r_pending, n_pending;
    logic                   fire;
    logic [7:0]             b;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !i_full && !r_pending;
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign o_push        = fire;

    // Classify the byte and advance framing and the tag scan.
    always_comb begin
        n_interval   = r_interval;
        n_audio_left = r_audio_left;
        n_phase      = r_phase;
        n_meta_left  = r_meta_left;
        n_meta_pos   = r_meta_pos;
        n_step       = r_step;
        n_count      = r_count;
        o_cmd.kind   = KIND_AUDIO;
        o_cmd.data   = b;
        o_cmd.run    = '0;
        o_store_wr.en   = 1'b0;
        o_store_wr.addr = r_count[TITLE_IDX_W-1:0];
        o_store_wr.data = b;

        if (i_cfg_valid) begin
            n_interval   = i_cfg_data;
            n_audio_left = i_cfg_data;
            n_phase      = PH_AUDIO;
            n_meta_left  = '0;
            n_meta_pos   = '0;
            n_step       = '0;
            n_count      = '0;
        end else if (fire) begin
            case (r_phase)
                PH_META: begin
                    o_cmd.kind  = KIND_META;
                    n_meta_pos  = r_meta_pos + 12'd1;
                    n_meta_left = r_meta_left - 12'd1;
                    if (r_meta_left == 12'd1) begin
                        n_phase = PH_AUDIO;
                    end
                    // Tag scan on this metadata byte.
                    if (r_step == STEP_DONE) begin
                        n_step = r_step;
                    end else if ({1'b0, r_meta_pos} >= SCAN_LAST || b == 8'h00) begin
                        n_step = STEP_DONE;
                    end else if (r_step < PAT_LEN) begin
                        if (b == tag_char(r_step)) begin
                            n_step = r_step + 4'd1;
                        end else if (b == CHAR_S) begin
                            n_step = 4'd1;
                        end else begin
                            n_step = 4'd0;
                        end
                    end else if (r_step == STEP_SKIP) begin
                        n_step  = STEP_CAPTURE;
                        n_count = '0;
                    end else if (b == CHAR_SEMI) begin
                        n_step = STEP_DONE;
                        if (r_step == STEP_OVER) begin
                            o_cmd.run = TITLE_CNT_W'(TITLE_MAX);
                        end else if (r_count >= TITLE_CNT_W'(2)) begin
                            o_cmd.run = r_count - TITLE_CNT_W'(1);
                        end
                    end else if (r_step == STEP_CAPTURE) begin
                        if (r_count < TITLE_CNT_W'(TITLE_MAX)) begin
                            o_store_wr.en = 1'b1;
                            n_count       = r_count + TITLE_CNT_W'(1);
                        end else begin
                            n_step = STEP_OVER;
                        end
                    end
                end
                PH_AUDIO: begin
                    if (r_interval == 20'd0) begin
                        o_cmd.kind = KIND_AUDIO;
                    end else if (r_audio_left == 20'd0) begin
                        o_cmd.kind   = KIND_LEN;
                        n_audio_left = r_interval;
                        n_meta_left  = {b, 4'b0000};
                        n_meta_pos   = '0;
                        n_step       = '0;
                        n_count      = '0;
                        n_phase      = (b != 8'h00) ? PH_META : PH_AUDIO;
                    end else begin
                        n_audio_left = r_audio_left - 20'd1;
                    end
                end
                default: begin
                    n_phase = PH_AUDIO;
                end
            endcase
        end
    end

    // Hold off input while a title run is still being emitted.
    always_comb begin
        n_pending = r_pending;
        if (i_run_done) begin
            n_pending = 1'b0;
        end
        if (fire && o_cmd.run != '0) begin
            n_pending = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval   <= '0;
            r_audio_left <= '0;
            r_phase      <= PH_AUDIO;
            r_meta_left  <= '0;
            r_meta_pos   <= '0;
            r_step       <= '0;
            r_count      <= '0;
            r_pending    <= 1'b0;
        end else begin
            r_interval   <= n_interval;
            r_audio_left <= n_audio_left;
            r_phase      <= n_phase;
            r_meta_left  <= n_meta_left;
            r_meta_pos   <= n_meta_pos;
            r_step       <= n_step;
            r_count      <= n_count;
            r_pending    <= n_pending;
        end
    end

endmodule

// ===== hw/rtl/imd_queue.sv =====
// Short command queue between the front and back ends.
// Depends on imd_pkg for the command type and depth.
module imd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  imd_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output imd_pkg::t_cmd  o_cmd
);
    import imd_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QPTR_W+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/imd_back.sv =====
// Back end: drains commands, holds the title store and drives the output stream.
// Depends on imd_pkg; fed by imd_queue and by title store writes from imd_front.
module imd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  imd_pkg::t_cmd      i_q_cmd,
    output logic               o_q_pop,
    input  imd_pkg::t_store_wr i_store_wr,
    output logic               o_run_done,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,     // data
    output logic [1:0]         m_axis_tuser,     // kind
    output logic               m_axis_tlast      // title_last
);
    import imd_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_TITLE = 3'b100
    } t_bstate;

    t_bstate                r_state, n_state;
    logic [TITLE_IDX_W-1:0] r_idx, n_idx;
    logic [TITLE_CNT_W-1:0] r_run, n_run;
    logic                   r_out_valid, n_out_valid;
    t_kind                  r_out_kind, n_out_kind;
    logic [7:0]             r_out_data, n_out_data;
    logic                   r_out_last, n_out_last;
    logic [7:0]             r_store [TITLE_MAX];
    logic [7:0]             r_rd_data;
    logic                   load_ok;
    logic                   is_last;

    assign load_ok = !r_out_valid || m_axis_tready;
    assign is_last = (TITLE_CNT_W'(r_idx) == r_run - TITLE_CNT_W'(1));

    // Title store: written by the front, read at the current run index.
    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[i_store_wr.addr] <= i_store_wr.data;
        end
        r_rd_data <= r_store[r_idx];
    end

    // Emit each byte's own result, then any title run it releases.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_run       = r_run;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_kind  = r_out_kind;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        o_q_pop     = 1'b0;
        o_run_done  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_q_valid && load_ok) begin
                    o_q_pop     = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = i_q_cmd.kind;
                    n_out_data  = i_q_cmd.data;
                    n_out_last  = 1'b0;
                    if (i_q_cmd.run != '0) begin
                        n_run   = i_q_cmd.run;
                        n_idx   = '0;
                        n_state = B_FETCH;
                    end
                end
            end
            B_FETCH: begin
                n_state = B_TITLE;
            end
            B_TITLE: begin
                if (load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_TITLE;
                    n_out_data  = r_rd_data;
                    n_out_last  = is_last;
                    if (is_last) begin
                        o_run_done = 1'b1;
                        n_state    = B_IDLE;
                    end else begin
                        n_idx   = r_idx + TITLE_IDX_W'(1);
                        n_state = B_FETCH;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_run       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
            r_run       <= n_run;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // Title reads never run past the store.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> (TITLE_CNT_W'(r_idx) < r_run))
        else $error("title index past run length");

    // A fetch cycle always hands over to the title emit step.
    a_fetch_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_FETCH) |=> (r_state == B_TITLE))
        else $error("fetch not followed by title step");

    // The last-character flag only marks title results.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_kind == KIND_TITLE))
        else $error("title_last on a non-title result");

    // No command is drained while a title run is in progress.
    a_no_pop_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != B_IDLE) |-> !o_q_pop)
        else $error("queue popped during title run");
`endif

endmodule

// ===== hw/rtl/icy_metadata_stream_demux_top.sv =====
// A byte's result goes through the command queue into the output register.
// Throughput: one stream byte per cycle while no title run holds the input; a
// stalled output backs up through the four-entry command queue to the input.
// Each title character is read from the title store, then loaded into the output;
// input is held from the terminating ';' transfer until the last character loads.
// Reset: synchronous, active-low i_rst_n clears the control registers only.
module icy_metadata_stream_demux_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [19:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,     // stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // data
    output logic [1:0]  m_axis_tuser,     // kind
    output logic        m_axis_tlast      // title_last
);
    import imd_pkg::*;

    t_cmd      push_cmd, head_cmd;
    t_store_wr store_wr;
    logic      push, full, pop, head_valid, run_done;

    // The register is always writable.
    assign o_cfg_ready = 1'b1;

    imd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .i_full       (full),
        .o_push       (push),
        .o_cmd        (push_cmd),
        .o_store_wr   (store_wr),
        .i_run_done   (run_done)
    );

    imd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(head_valid),
        .o_cmd  (head_cmd)
    );

    imd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (head_valid),
        .i_q_cmd      (head_cmd),
        .o_q_pop      (pop),
        .i_store_wr   (store_wr),
        .o_run_done   (run_done),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the stream metadata demultiplexer top level.
// Depends on imd_pkg and icy_metadata_stream_demux_top. It drives the stream and
// configuration ports and checks every output transfer against a built-in predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int TAG_LEN        = 12;

    localparam logic [95:0] TAG_TEXT     = "StreamTitle=";
    localparam logic [7:0]  CH_QUOTE     = 8'h27;
    localparam logic [7:0]  CH_SEMI      = 8'h3B;
    localparam logic [7:0]  CH_NUL       = 8'h00;
    localparam logic [7:0]  CH_BROKEN    = 8'h2A;
    localparam logic [19:0] INTERVAL_MAX = 20'hFFFFF;

    // Progress of the title search past the tag itself.
    localparam logic [3:0] SCAN_SKIP    = 4'd12;
    localparam logic [3:0] SCAN_CAPTURE = 4'd13;
    localparam logic [3:0] SCAN_DONE    = 4'd14;
    localparam logic [3:0] SCAN_OVER    = 4'd15;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } t_row_op;

    // One row of the directed table; typed rows carry their first result.
    typedef struct packed {
        t_row_op     op;
        logic [19:0] value;
        logic        typed;
        t_kind       kind;
        logic [7:0]  data;
        logic        last;
    } t_stim_row;

    // One output transfer as the predictor expects it.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic       last;
    } t_demux_item;

    // Clock, reset and block ports.
    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;     // data
    logic [1:0]  m_axis_tuser;     // kind
    logic        m_axis_tlast;     // title_last

    // Predictor state.
    logic [19:0] interval_cfg;
    logic [19:0] audio_to_go;
    logic        in_meta;
    logic [11:0] meta_to_go;
    logic [11:0] meta_index;
    logic [3:0]  tag_progress;
    logic [7:0]  title_chars [TITLE_MAX];
    logic [5:0]  title_fill;

    t_demux_item expected_items [$];
    logic [7:0]  meta_body [$];
    t_stim_row   directed_rows [26];

    int fail_count     = 0;
    int bytes_sent     = 0;
    int cfg_writes     = 0;
    int title_runs     = 0;
    int kind_seen [4]  = '{0, 0, 0, 0};
    int last_slot      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_tick      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    icy_metadata_stream_demux_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // 2 ns clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [7:0] tag_byte(input int i);
        return TAG_TEXT[95 - 8 * i -: 8];
    endfunction

    function automatic void expect_item(input t_kind k, input logic [7:0] d, input logic l);
        t_demux_item item;
        item.kind = k;
        item.data = d;
        item.last = l;
        expected_items.push_back(item);
    endfunction

    // A register write restarts framing in the audio phase.
    function automatic void apply_interval(input logic [19:0] v);
        interval_cfg = v;
        audio_to_go  = v;
        in_meta      = 1'b0;
        meta_to_go   = '0;
        meta_index   = '0;
        tag_progress = '0;
        title_fill   = '0;
    endfunction

    // Title search on one metadata byte; a ';' after a capture releases the run.
    function automatic void scan_for_title(input logic [7:0] b);
        int run;
        int i;
        run = 0;
        if (tag_progress == SCAN_DONE)
            return;
        if (int'(meta_index) >= SCAN_LIMIT - 1 || b == CH_NUL) begin
            tag_progress = SCAN_DONE;
            return;
        end
        if (int'(tag_progress) < TAG_LEN) begin
            if (b == tag_byte(int'(tag_progress)))
                tag_progress = tag_progress + 4'd1;
            else
                tag_progress = (b == tag_byte(0)) ? 4'd1 : 4'd0;
            return;
        end
        if (tag_progress == SCAN_SKIP) begin
            tag_progress = SCAN_CAPTURE;
            title_fill   = '0;
            return;
        end
        if (b == CH_SEMI) begin
            if (tag_progress == SCAN_OVER)
                run = TITLE_MAX;
            else if (title_fill >= 6'd2)
                run = int'(title_fill) - 1;
            tag_progress = SCAN_DONE;
            for (i = 0; i < run; i++)
                expect_item(KIND_TITLE, title_chars[i], i == run - 1);
            return;
        end
        if (tag_progress == SCAN_CAPTURE) begin
            if (int'(title_fill) < TITLE_MAX) begin
                title_chars[title_fill] = b;
                title_fill = title_fill + 6'd1;
            end else begin
                tag_progress = SCAN_OVER;
            end
        end
    endfunction

    // Expected results of one accepted stream byte.
    function automatic void demux_predict(input logic [7:0] b);
        if (in_meta) begin
            expect_item(KIND_META, b, 1'b0);
            scan_for_title(b);
            meta_index = meta_index + 12'd1;
            meta_to_go = meta_to_go - 12'd1;
            if (meta_to_go == 12'd0)
                in_meta = 1'b0;
        end else if (interval_cfg == '0) begin
            expect_item(KIND_AUDIO, b, 1'b0);
        end else if (audio_to_go == '0) begin
            expect_item(KIND_LEN, b, 1'b0);
            audio_to_go  = interval_cfg;
            meta_to_go   = {b, 4'h0};
            meta_index   = '0;
            tag_progress = '0;
            title_fill   = '0;
            in_meta      = (meta_to_go != '0);
        end else begin
            expect_item(KIND_AUDIO, b, 1'b0);
            audio_to_go = audio_to_go - 20'd1;
        end
    endfunction

    function automatic logic [7:0] title_char();
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == CH_SEMI)
            c = 8'h20;
        return c;
    endfunction

    // Tag, quote, title text, closing quote and optionally the terminator.
    function automatic void add_title_entry(input int text_n, input logic ends, input int bad_pos);
        int i;
        for (i = 0; i < TAG_LEN; i++)
            meta_body.push_back((i == bad_pos) ? CH_BROKEN : tag_byte(i));
        meta_body.push_back(CH_QUOTE);
        for (i = 0; i < text_n; i++)
            meta_body.push_back(title_char());
        meta_body.push_back(CH_QUOTE);
        if (ends)
            meta_body.push_back(CH_SEMI);
    endfunction

    // Builds the content of one metadata block, mostly well-formed.
    function automatic void build_meta_block();
        int i;
        int n;
        meta_body.delete();
        if ($urandom_range(1) == 1) begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++)
                meta_body.push_back(8'($urandom_range(1, 255)));
        end
        // A partial tag ahead of the real one makes the search restart.
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(1, TAG_LEN - 1);
            for (i = 0; i < n; i++)
                meta_body.push_back(tag_byte(i));
        end
        case ($urandom_range(9))
            0:       n = $urandom_range(0, 1);
            1, 2:    n = $urandom_range(TITLE_MAX - 3, TITLE_MAX + 10);
            default: n = $urandom_range(2, 12);
        endcase
        add_title_entry(n, $urandom_range(9) != 0,
                        ($urandom_range(9) == 0) ? $urandom_range(0, TAG_LEN - 1) : -1);
        if ($urandom_range(4) == 0)
            add_title_entry($urandom_range(1, 8), 1'b1, -1);
        n = $urandom_range(0, 8);
        for (i = 0; i < n; i++)
            meta_body.push_back(8'($urandom_range(1, 255)));
        // A stray NUL ends the scan wherever it lands.
        if ($urandom_range(9) == 0)
            meta_body[$urandom_range(0, meta_body.size() - 1)] = CH_NUL;
    endfunction

    // Offers one byte, idling first at random, and predicts it once accepted.
    task automatic send_stream_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        last_slot = expected_items.size();
        demux_predict(b);
        bytes_sent++;
    endtask

    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_items.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes happen only with the block idle.
    task automatic write_interval(input logic [19:0] v);
        wait_until_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_interval(v);
        cfg_writes++;
    endtask

    // One frame: a run of audio bytes, the length byte and the metadata block.
    task automatic send_frame(input int audio_n);
        int i;
        int units;
        int r;
        logic pad_noise;
        for (i = 0; i < audio_n; i++)
            send_stream_byte(8'($urandom));
        build_meta_block();
        units = (meta_body.size() + 15) / 16;
        r = $urandom_range(19);
        if (r == 0)
            units = 0;
        else if (r <= 2 && units > 1)
            units = $urandom_range(1, units - 1);
        else if (r == 3)
            units = units + 1;
        pad_noise = ($urandom_range(3) == 0);
        send_stream_byte(8'(units));
        for (i = 0; i < units * 16; i++) begin
            if (i < meta_body.size())
                send_stream_byte(meta_body[i]);
            else
                send_stream_byte(pad_noise ? 8'($urandom_range(1, 255)) : CH_NUL);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_seen != hold_tick) begin
            hold_seen     <= hold_tick;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each output transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_demux_item want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_items.size() == 0) begin
                $error("unexpected result: kind %0d data 0x%02h last %0b",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                fail_count++;
            end else begin
                want = expected_items.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", want.kind, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata !== want.data) begin
                    $error("data mismatch: expected 0x%02h, actual 0x%02h",
                           want.data, m_axis_tdata);
                    fail_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("title_last mismatch: expected %0b, actual %0b",
                           want.last, m_axis_tlast);
                    fail_count++;
                end
                kind_seen[int'(want.kind)]++;
                if (want.kind == KIND_TITLE && want.last)
                    title_runs++;
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_items.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // Reset, directed table, random frames under the four idling phases, final report.
    initial begin : stimulus
        int r;
        int mode;
        int f;
        int i;
        int frames;
        logic [19:0] gap;
        t_stim_row row;

        directed_rows = '{
            '{ROW_BYTE, 20'h00,  1'b1, KIND_AUDIO, 8'h00, 1'b0},   // no metadata
            '{ROW_BYTE, 20'hFF,  1'b1, KIND_AUDIO, 8'hFF, 1'b0},
            '{ROW_CFG,  20'd2,   1'b0, KIND_AUDIO, 8'h00, 1'b0},
            '{ROW_BYTE, 20'h5A,  1'b1, KIND_AUDIO, 8'h5A, 1'b0},
            '{ROW_BYTE, 20'hA5,  1'b1, KIND_AUDIO, 8'hA5, 1'b0},
            '{ROW_BYTE, 20'h00,  1'b1, KIND_LEN,   8'h00, 1'b0},   // empty block
            '{ROW_BYTE, 20'h3C,  1'b1, KIND_AUDIO, 8'h3C, 1'b0},
            '{ROW_BYTE, 20'hC3,  1'b1, KIND_AUDIO, 8'hC3, 1'b0},
            '{ROW_BYTE, 20'h01,  1'b1, KIND_LEN,   8'h01, 1'b0},   // one 16-byte block
            '{ROW_BYTE, 20'h53,  1'b1, KIND_META,  8'h53, 1'b0},   // S
            '{ROW_BYTE, 20'h74,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // t
            '{ROW_BYTE, 20'h72,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // r
            '{ROW_BYTE, 20'h65,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // e
            '{ROW_BYTE, 20'h61,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // a
            '{ROW_BYTE, 20'h6D,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // m
            '{ROW_BYTE, 20'h54,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // T
            '{ROW_BYTE, 20'h69,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // i
            '{ROW_BYTE, 20'h74,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // t
            '{ROW_BYTE, 20'h6C,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // l
            '{ROW_BYTE, 20'h65,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // e
            '{ROW_BYTE, 20'h3D,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // =
            '{ROW_BYTE, 20'h27,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // opening quote
            '{ROW_BYTE, 20'h41,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // A
            '{ROW_BYTE, 20'h27,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // closing quote
            '{ROW_BYTE, 20'h3B,  1'b0, KIND_AUDIO, 8'h00, 1'b0},   // ; releases "A"
            '{ROW_BYTE, 20'h77,  1'b1, KIND_AUDIO, 8'h77, 1'b0}    // audio resumes
        };
        apply_interval('0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (r = 0; r < $size(directed_rows); r++) begin
            row = directed_rows[r];
            if (row.op == ROW_CFG) begin
                write_interval(row.value);
            end else begin
                send_stream_byte(row.value[7:0]);
                if (row.typed)
                    expected_items[last_slot] = '{row.kind, row.data, row.last};
            end
        end

        // Random frames, one idling phase at a time.
        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            gap = (mode == 0) ? 20'd1 : 20'($urandom_range(2, 12));
            write_interval(gap);
            frames = (mode == 1) ? 2 : 1;
            for (f = 0; f < frames; f++) begin
                // The output backs up while input keeps coming.
                if (mode == 0 && f == 0)
                    hold_tick++;
                // The sender pauses between frames until all results are out.
                if (mode == 1 && f == 1)
                    wait_until_drained();
                send_frame(int'(gap));
            end
            // Audio-only settings: no metadata, full-scale and a random wide interval.
            case (mode)
                0:       gap = '0;
                1:       gap = INTERVAL_MAX;
                2:       gap = 20'($urandom_range(16, INTERVAL_MAX));
                default: gap = '0;
            endcase
            write_interval(gap);
            for (i = 0; i < 6; i++)
                send_stream_byte(8'($urandom));
        end

        wait_until_drained();
        $display("Run covered %0d stream bytes across %0d interval settings and four idling phases.",
                 bytes_sent, cfg_writes);
        $display("Seen %0d audio, %0d length, %0d metadata, %0d title bytes in %0d title runs.",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], title_runs);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
